[sv/mpq_pkg.sv]
// Shared types and codes for the sorted-cell min-priority queue.
`timescale 1ns / 1ps

package mpq_pkg;

    // Width of one stored key.
    localparam int KEY_W = 32;

    // Operation codes carried on the operation port.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Status codes returned with each result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } mpq_ctrl_t;

endpackage

[sv/min_priority_queue.sv]
// Top level of the min-priority queue built as a row of sorted cells.
//
//   channel   direction  handshake          payload
//   command   in         start / busy       operation, value
//   result    out        done (one cycle)   result_value, status, occupancy
//
// One item is taken every cycle; busy stays low.
// The result of an item appears with done on the cycle after it is accepted.
// Every cell compares its key with the broadcast key at once, so an insert or
// remove updates the registers of the whole row together.
// Reset clears the count and the result strobe; stored keys are not cleared.
// The receiver cannot stall, so nothing holds the row back.
`timescale 1ns / 1ps

module min_priority_queue
    import mpq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              operation,
    input  logic signed [KEY_W-1:0] value,
    output logic                    done,
    output logic signed [KEY_W-1:0] result_value,
    output logic [1:0]              status,
    output logic [4:0]              occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    done_reg;
    logic signed [KEY_W-1:0] result_reg;
    logic signed [KEY_W-1:0] result_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic [4:0]              occ_reg;

    logic                    accept;
    logic                    full;
    logic                    empty;
    mpq_ctrl_t               ctrl;
    logic [CAPACITY-1:0]     lt;
    logic signed [KEY_W-1:0] entry [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);

    // Decode the operation into a row command, new count and result.
    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        result_next = '0;
        status_next = ST_OK;
        if (accept)
        begin
            unique case (op_t'(operation))
                OP_INSERT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.insert_en = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        ctrl.remove_en = 1'b1;
                        result_next    = entry[0];
                        count_next     = count_reg - 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                        result_next = entry[0];
                end
                OP_NOP:
                begin
                    status_next = ST_OK;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // The row of cells; each neighbor link is a fixed wire.
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                    left_lt_w;
            logic signed [KEY_W-1:0] left_w;
            logic signed [KEY_W-1:0] right_w;

            if (i == 0)
            begin : g_head
                assign left_lt_w = 1'b1;
                assign left_w    = value;
            end
            else
            begin : g_mid
                assign left_lt_w = lt[i-1];
                assign left_w    = entry[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_w = '0;
            end
            else
            begin : g_body
                assign right_w = entry[i+1];
            end

            mpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .key         (value),
                .occupied    (CNT_W'(i) < count_reg),
                .left_lt     (left_lt_w),
                .left_value  (left_w),
                .right_value (right_w),
                .lt          (lt[i]),
                .entry       (entry[i])
            );
        end
    endgenerate

    // Count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
            occ_reg    <= 5'(count_next);
        end
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

    // Every accepted item gives exactly one result on the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without an accepted item");

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // An empty report leaves the queue empty.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status_reg == ST_EMPTY) |-> (count_reg == '0))
        else $error("empty status with stored entries");

    // A successful remove lowers the count by one.
    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == OP_REMOVE) && !empty
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not lower the count");

endmodule

[sv/mpq_cell.sv]
// One cell of the sorted row: holds a key and trades it with its neighbors.
`timescale 1ns / 1ps

module mpq_cell
    import mpq_pkg::*;
(
    input  logic                    clk,
    input  mpq_ctrl_t               ctrl,
    input  logic signed [KEY_W-1:0] key,
    input  logic                    occupied,
    input  logic                    left_lt,
    input  logic signed [KEY_W-1:0] left_value,
    input  logic signed [KEY_W-1:0] right_value,
    output logic                    lt,
    output logic signed [KEY_W-1:0] entry
);

    logic signed [KEY_W-1:0] entry_reg;
    logic signed [KEY_W-1:0] entry_next;

    // The row is sorted, so the lt flags form a run of ones from the head.
    assign lt    = occupied && (entry_reg < key);
    assign entry = entry_reg;

    // Keep, take the new key, shift in from the left, or shift in from the right.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en)
        begin
            if (lt)
                entry_next = entry_reg;
            else if (left_lt)
                entry_next = key;
            else
                entry_next = left_value;
        end
        else if (ctrl.remove_en)
        begin
            entry_next = right_value;
        end
    end

    // Key storage needs no reset; keys in cells at or above the count never reach a result or an lt flag.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
